>>> rtl/b2n_pkg.sv
// b2n_pkg: shared types and constants of the BGRA to NV12 converter.
// No dependencies; every other file refers to it by scoped names.

package b2n_pkg;

   // Positions on the result channel are fixed at 11 bits.
   localparam int POS_W = 11;
   localparam int CSR_DATA_W = 12;

   localparam int FRAME_WIDTH_RST = 1920;
   localparam int FRAME_HEIGHT_RST = 1080;

   // Result queue: sized so a full pipeline never overruns it.
   localparam int RSP_FIFO_DEPTH = 8;
   localparam int RSP_PTR_W = 3;
   localparam int RSP_CNT_W = 4;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic             plane;
      logic [7:0]       luma;
      logic [7:0]       chroma_blue;
      logic [7:0]       chroma_red;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] column;
      logic             last_of_run;
      logic             frame_end;
   } result_type;

   // Upper-row pair sums, R high as in the line store layout.
   typedef struct packed {
      logic [8:0] red;
      logic [8:0] green;
      logic [8:0] blue;
   } sum_type;

   // One pixel in flight between the front end and the color math.
   typedef struct packed {
      pixel_type        pixel;
      sum_type          part_sum;
      logic             pair;
      logic             use_line;
      logic             block_done;
      logic             frame_end;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] blk_row;
      logic [POS_W-1:0] blk_column;
   } tok_type;

   // Up to two words written into the result queue in one cycle.
   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } push_type;

endpackage

>>> rtl/bgra_to_nv12_converter_unit.sv
// Each pixel passes the front and color registers into the result queue, its
// chroma word (if it closes a 2x2 block) right behind its luma word. Throughput:
// one pixel per cycle in while the queue has room; one word per cycle out while
// rsp_ready is high, so with chroma on every fourth pixel the result port sets
// the pace. Reset (synchronous): counters, pipeline and queue clear, size returns
// to 1920x1080, input not ready; the line store is not cleared (written first).

module bgra_to_nv12_converter_unit #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  b2n_pkg::pixel_type                    req_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output b2n_pkg::result_type                   rsp_result,
   input  logic                                  csr_we,
   input  b2n_pkg::csr_index_type                csr_index,
   input  logic [b2n_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam logic [WW-1:0] W_RST = WW'((b2n_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                                         MAX_WIDTH : b2n_pkg::FRAME_WIDTH_RST);
   localparam logic [HW-1:0] H_RST = HW'((b2n_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                                         MAX_HEIGHT : b2n_pkg::FRAME_HEIGHT_RST);
   localparam int NW = b2n_pkg::RSP_CNT_W + 1;

   logic [WW-1:0] width_ff, width_in, w_clamp;
   logic [HW-1:0] height_ff, height_in, h_clamp;

   // size 0 acts as 1, oversize acts as the maximum
   assign w_clamp = (csr_wdata == '0) ? WW'(1) :
                    ((32'(csr_wdata) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(csr_wdata));
   assign h_clamp = (csr_wdata == '0) ? HW'(1) :
                    ((32'(csr_wdata) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(csr_wdata));

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            b2n_pkg::CSR_FRAME_WIDTH:  width_in  = w_clamp;
            b2n_pkg::CSR_FRAME_HEIGHT: height_in = h_clamp;
            default:                   width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= W_RST;
         height_ff <= H_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   logic                accept;
   logic                tok_valid;
   b2n_pkg::tok_type    tok;
   b2n_pkg::sum_type    line_q;
   b2n_pkg::push_type   push;
   logic [b2n_pkg::RSP_CNT_W-1:0] fill;
   logic [NW-1:0]       committed;

   // queue words plus words still in the two stages, plus room for one more pixel
   assign committed = NW'(fill)
                    + (tok_valid ? NW'(1) + NW'(tok.block_done) : NW'(0))
                    + NW'(push.first_valid) + NW'(push.second_valid);
   assign req_ready = !reset && (committed <= NW'(b2n_pkg::RSP_FIFO_DEPTH - 2));
   assign accept    = req_valid && req_ready;

   b2n_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pixel     (req_pixel),
      .frame_w   (width_ff),
      .frame_h   (height_ff),
      .restart   (csr_we),
      .tok_valid (tok_valid),
      .tok       (tok),
      .line_q    (line_q)
   );

   b2n_color u_color (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (tok_valid),
      .tok       (tok),
      .line_q    (line_q),
      .push      (push)
   );

   b2n_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_valid && rsp_ready),
      .out_valid (rsp_valid),
      .out_word  (rsp_result),
      .fill      (fill)
   );

endmodule

>>> rtl/b2n_front.sv
// b2n_front: raster counters, held even pixel and the line store of
// upper-row pair sums. Depends on b2n_pkg.

module b2n_front #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  b2n_pkg::pixel_type                    pixel,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]        frame_w,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]       frame_h,
   input  logic                                  restart,
   output logic                                  tok_valid,
   output b2n_pkg::tok_type                      tok,
   output b2n_pkg::sum_type                      line_q
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   b2n_pkg::pixel_type  held_ff, held_in;
   logic                tok_valid_ff;
   b2n_pkg::tok_type    tok_ff, tok_in;
   b2n_pkg::sum_type    line_q_ff;
   b2n_pkg::sum_type    line_mem [LINE_DEPTH];

   logic                last_col, last_row, hold, wr_line, done;
   logic [AW-1:0]       idx;
   b2n_pkg::sum_type    sum_now;

   assign last_col = (WW'(col_ff) + WW'(1)) >= frame_w;
   assign last_row = (HW'(row_ff) + HW'(1)) >= frame_h;
   assign idx      = AW'(col_ff >> 1);

   // even column with a partner to come: park it
   assign hold    = !col_ff[0] && !last_col;
   // upper row of a two-row block: leave the pair sum for the next row
   assign wr_line = !hold && !row_ff[0] && !last_row;
   assign done    = !hold && !wr_line;

   always_comb begin
      sum_now.red   = 9'(pixel.red)   + (col_ff[0] ? 9'(held_ff.red)   : 9'd0);
      sum_now.green = 9'(pixel.green) + (col_ff[0] ? 9'(held_ff.green) : 9'd0);
      sum_now.blue  = 9'(pixel.blue)  + (col_ff[0] ? 9'(held_ff.blue)  : 9'd0);
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      held_in = held_ff;
      priority if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (hold) begin
            held_in = pixel;
         end
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end else begin
         col_in = col_ff;
      end
   end

   always_comb begin
      tok_in.pixel      = pixel;
      tok_in.part_sum   = sum_now;
      tok_in.pair       = col_ff[0];
      tok_in.use_line   = done && row_ff[0];
      tok_in.block_done = done;
      tok_in.frame_end  = last_col && last_row;
      tok_in.row        = b2n_pkg::POS_W'(row_ff);
      tok_in.column     = b2n_pkg::POS_W'(col_ff);
      tok_in.blk_row    = b2n_pkg::POS_W'(row_ff >> 1);
      tok_in.blk_column = b2n_pkg::POS_W'(col_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         held_ff      <= '0;
         tok_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         held_ff      <= held_in;
         tok_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tok_ff <= tok_in;
      end
   end

   // The lower row reads an entry at least one pixel after the upper row
   // wrote it, and no pixel that writes an entry uses what it reads, so a
   // plain registered read always sees the fresh pair sum.
   always_ff @(posedge clock) begin
      if (accept && wr_line) begin
         line_mem[idx] <= sum_now;
      end
      if (accept) begin
         line_q_ff <= line_mem[idx];
      end
   end

   assign tok_valid = tok_valid_ff;
   assign tok       = tok_ff;
   assign line_q    = line_q_ff;

endmodule

>>> rtl/b2n_color.sv
// b2n_color: block averaging, BT.601 luma and chroma math, two stages.
// Depends on b2n_pkg.

module b2n_color (
   input  logic               clock,
   input  logic               reset,
   input  logic               tok_valid,
   input  b2n_pkg::tok_type   tok,
   input  b2n_pkg::sum_type   line_q,
   output b2n_pkg::push_type  push
);

   localparam logic [15:0] Y_R = 16'd66;
   localparam logic [15:0] Y_G = 16'd129;
   localparam logic [15:0] Y_B = 16'd25;
   localparam logic [15:0] ROUND = 16'd128;
   localparam logic [8:0]  Y_OFS = 9'd16;
   localparam logic signed [17:0] C_OFS = 18'sd32896; // rounding plus 128 << 8
   localparam logic signed [17:0] CB_R = -18'sd38;
   localparam logic signed [17:0] CB_G = -18'sd74;
   localparam logic signed [17:0] CB_B = 18'sd112;
   localparam logic signed [17:0] CR_R = 18'sd112;
   localparam logic signed [17:0] CR_G = -18'sd94;
   localparam logic signed [17:0] CR_B = -18'sd18;

   function automatic logic [7:0] sat8(input logic signed [17:0] v);
      logic signed [9:0] q;
      q = v[17:8];
      if (q < 0) begin
         return 8'd0;
      end else if (q > 10'sd255) begin
         return 8'd255;
      end
      return q[7:0];
   endfunction

   // stage B: finish the block sums, average, luma
   logic [9:0]  sr, sg, sb;
   logic [1:0]  sh;
   logic [15:0] y_sum;
   logic [8:0]  y_pre;
   b2n_pkg::pixel_type avg_in;
   logic [7:0]  luma_in;

   always_comb begin
      sr = 10'(tok.part_sum.red)   + (tok.use_line ? 10'(line_q.red)   : 10'd0);
      sg = 10'(tok.part_sum.green) + (tok.use_line ? 10'(line_q.green) : 10'd0);
      sb = 10'(tok.part_sum.blue)  + (tok.use_line ? 10'(line_q.blue)  : 10'd0);
      sh = {1'b0, tok.pair} + {1'b0, tok.use_line};
      avg_in.red   = 8'(sr >> sh);
      avg_in.green = 8'(sg >> sh);
      avg_in.blue  = 8'(sb >> sh);
      y_sum = Y_R * 16'(tok.pixel.red) + Y_G * 16'(tok.pixel.green)
            + Y_B * 16'(tok.pixel.blue) + ROUND;
      y_pre = {1'b0, y_sum[15:8]} + Y_OFS;
      luma_in = (y_pre > 9'd255) ? 8'd255 : y_pre[7:0];
   end

   logic               c_valid_ff;
   b2n_pkg::tok_type   c_tok_ff;
   b2n_pkg::pixel_type c_avg_ff;
   logic [7:0]         c_luma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= tok_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_valid) begin
         c_tok_ff  <= tok;
         c_avg_ff  <= avg_in;
         c_luma_ff <= luma_in;
      end
   end

   // stage C: chroma, then build the result words
   logic signed [17:0] ar, ag, ab, u_sum, v_sum;

   always_comb begin
      ar = $signed({10'd0, c_avg_ff.red});
      ag = $signed({10'd0, c_avg_ff.green});
      ab = $signed({10'd0, c_avg_ff.blue});
      u_sum = C_OFS + CB_R * ar + CB_G * ag + CB_B * ab;
      v_sum = C_OFS + CR_R * ar + CR_G * ag + CR_B * ab;

      push.first_valid        = c_valid_ff;
      push.second_valid       = c_valid_ff && c_tok_ff.block_done;

      push.first.plane        = 1'b0;
      push.first.luma         = c_luma_ff;
      push.first.chroma_blue  = 8'd0;
      push.first.chroma_red   = 8'd0;
      push.first.row          = c_tok_ff.row;
      push.first.column       = c_tok_ff.column;
      push.first.last_of_run  = !c_tok_ff.block_done;
      push.first.frame_end    = c_tok_ff.frame_end && !c_tok_ff.block_done;

      push.second.plane       = 1'b1;
      push.second.luma        = 8'd0;
      push.second.chroma_blue = sat8(u_sum);
      push.second.chroma_red  = sat8(v_sum);
      push.second.row         = c_tok_ff.blk_row;
      push.second.column      = c_tok_ff.blk_column;
      push.second.last_of_run = 1'b1;
      push.second.frame_end   = c_tok_ff.frame_end;
   end

endmodule

>>> rtl/b2n_rsp_fifo.sv
// b2n_rsp_fifo: result queue taking up to two words per cycle, one out.
// Depends on b2n_pkg.

module b2n_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  b2n_pkg::push_type                   push,
   input  logic                                pop,
   output logic                                out_valid,
   output b2n_pkg::result_type                 out_word,
   output logic [b2n_pkg::RSP_CNT_W-1:0]       fill
);

   localparam int PW = b2n_pkg::RSP_PTR_W;
   localparam int NW = b2n_pkg::RSP_CNT_W;

   b2n_pkg::result_type q_mem [b2n_pkg::RSP_FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic [1:0]    n_push;

   assign n_push    = {1'b0, push.first_valid} + {1'b0, push.second_valid};
   assign wr_ptr_in = wr_ptr_ff + PW'(n_push);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + NW'(n_push) - NW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         q_mem[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         q_mem[wr_ptr_ff + PW'(1)] <= push.second;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_word  = q_mem[rd_ptr_ff];
   assign fill      = count_ff;

endmodule

>>> rtl/b2n_checker.sv
// b2n_checker: port-level checks of the converter's result stream.
// Depends on b2n_pkg; bound to bgra_to_nv12_converter_unit below.

module b2n_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input b2n_pkg::result_type  rsp_result
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
      else $error("result word changed while stalled");

   // a chroma word always closes its pixel's run
   a_chroma_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result.plane |-> rsp_result.last_of_run)
      else $error("chroma word without last_of_run");

   // a luma word that does not close its run is followed at once by chroma
   a_luma_then_chroma: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_result.plane && !rsp_result.last_of_run
      |=> rsp_valid && rsp_result.plane)
      else $error("chroma word missing after luma word");

   // the frame's final word is the last word of its pixel
   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result.frame_end |-> rsp_result.last_of_run)
      else $error("frame_end on a word that is not last_of_run");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind bgra_to_nv12_converter_unit b2n_checker u_b2n_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_result (rsp_result)
);
